// ===== rtl/lowest_common_ancestor_lifting_macros.svh =====
// Assertion macros for the lowest common ancestor block.
// Used by the top level only; no other dependencies.
`ifndef LOWEST_COMMON_ANCESTOR_LIFTING_MACROS_SVH
`define LOWEST_COMMON_ANCESTOR_LIFTING_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define LCAL_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define LCAL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/lcal_pkg.sv =====
// Shared types and constants for the lowest common ancestor block.
// Used by the controller, the datapath and the top level.
package lcal_pkg;

    // Tree size and table geometry. The node number space equals the capacity,
    // so node numbers are used as table indexes directly.
    localparam int NODE_W        = 14;
    localparam int NODE_CAPACITY = 1 << NODE_W;
    localparam int LIFT_LEVELS   = 14;
    localparam int LVL_W         = (LIFT_LEVELS > 1) ? $clog2(LIFT_LEVELS) : 1;
    localparam int DEPTH_W       = 14;
    localparam int ANC_DEPTH     = LIFT_LEVELS * NODE_CAPACITY;
    localparam int ANC_AW        = LVL_W + NODE_W;

    // Operation codes carried by the func field.
    typedef enum logic {
        FUNC_LOAD  = 1'b0,
        FUNC_QUERY = 1'b1
    } t_func;

    // Datapath operations issued by the controller.
    typedef enum logic [3:0] {
        DP_NONE,
        DP_CAPTURE,
        DP_LD_BASE,
        DP_DEP_WR,
        DP_DEP_RD,
        DP_LD_RD,
        DP_LD_WR,
        DP_SETUP,
        DP_LIFT_RD,
        DP_LIFT_WR,
        DP_SHIFT,
        DP_DESC_RD,
        DP_DESC_UPD,
        DP_FIN_RD,
        DP_OUT_A,
        DP_OUT_RD
    } t_op;

    // Command from controller to datapath.
    typedef struct packed {
        t_op              op;
        logic [LVL_W-1:0] lvl;
    } t_cmd;

    // Status from datapath to controller.
    typedef struct packed {
        logic eq;
        logic diff_zero;
        logic diff_lsb;
        logic out_free;
    } t_sts;

endpackage

// ===== rtl/lcal_ctrl.sv =====
// Sequencer for loads and queries of the lowest common ancestor block.
// Depends on lcal_pkg for the command and status types.
module lcal_ctrl import lcal_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_func,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [13:0] {
        S_IDLE     = 14'b00000000000001,
        S_LD_DEP   = 14'b00000000000010,
        S_LD_DWR   = 14'b00000000000100,
        S_LD_RD    = 14'b00000000001000,
        S_LD_WR    = 14'b00000000010000,
        S_Q_DEP    = 14'b00000000100000,
        S_Q_SET    = 14'b00000001000000,
        S_LIFT     = 14'b00000010000000,
        S_LIFT_WR  = 14'b00000100000000,
        S_DESC_RD  = 14'b00001000000000,
        S_DESC_UPD = 14'b00010000000000,
        S_FIN_RD   = 14'b00100000000000,
        S_OUT_A    = 14'b01000000000000,
        S_OUT_RD   = 14'b10000000000000
    } t_state;

    localparam logic [LVL_W-1:0] LVL_TOP = LVL_W'(LIFT_LEVELS - 1);

    t_state           r_state, n_state;
    logic [LVL_W-1:0] r_lvl, n_lvl;

    assign o_in_ready = (r_state == S_IDLE);

    // Next state, level counter and datapath command.
    always_comb begin
        n_state   = r_state;
        n_lvl     = r_lvl;
        o_cmd.op  = DP_NONE;
        o_cmd.lvl = r_lvl;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = DP_CAPTURE;
                    n_state  = (t_func'(i_func) == FUNC_LOAD) ? S_LD_DEP : S_Q_DEP;
                end
            end
            S_LD_DEP: begin
                o_cmd.op = DP_LD_BASE;
                n_lvl    = LVL_W'(1);
                n_state  = S_LD_DWR;
            end
            S_LD_DWR: begin
                o_cmd.op = DP_DEP_WR;
                n_state  = (LIFT_LEVELS > 1) ? S_LD_RD : S_IDLE;
            end
            S_LD_RD: begin
                // Read level below the one about to be written.
                o_cmd.op  = DP_LD_RD;
                o_cmd.lvl = r_lvl - LVL_W'(1);
                n_state   = S_LD_WR;
            end
            S_LD_WR: begin
                o_cmd.op = DP_LD_WR;
                if (r_lvl == LVL_TOP) begin
                    n_state = S_IDLE;
                end else begin
                    n_lvl   = r_lvl + LVL_W'(1);
                    n_state = S_LD_RD;
                end
            end
            S_Q_DEP: begin
                o_cmd.op = DP_DEP_RD;
                n_state  = S_Q_SET;
            end
            S_Q_SET: begin
                o_cmd.op = DP_SETUP;
                n_lvl    = '0;
                n_state  = S_LIFT;
            end
            S_LIFT: begin
                // Walk the difference bits from the bottom until none are left.
                if (i_sts.diff_zero) begin
                    n_lvl   = LVL_TOP;
                    n_state = i_sts.eq ? S_OUT_A : S_DESC_RD;
                end else if (i_sts.diff_lsb) begin
                    o_cmd.op = DP_LIFT_RD;
                    n_state  = S_LIFT_WR;
                end else begin
                    o_cmd.op = DP_SHIFT;
                    n_lvl    = r_lvl + LVL_W'(1);
                end
            end
            S_LIFT_WR: begin
                o_cmd.op = DP_LIFT_WR;
                n_lvl    = r_lvl + LVL_W'(1);
                n_state  = S_LIFT;
            end
            S_DESC_RD: begin
                o_cmd.op = DP_DESC_RD;
                n_state  = S_DESC_UPD;
            end
            S_DESC_UPD: begin
                o_cmd.op = DP_DESC_UPD;
                if (r_lvl == '0) begin
                    n_state = S_FIN_RD;
                end else begin
                    n_lvl   = r_lvl - LVL_W'(1);
                    n_state = S_DESC_RD;
                end
            end
            S_FIN_RD: begin
                o_cmd.op  = DP_FIN_RD;
                o_cmd.lvl = '0;
                n_state   = S_OUT_RD;
            end
            S_OUT_A: begin
                if (i_sts.out_free) begin
                    o_cmd.op = DP_OUT_A;
                    n_state  = S_IDLE;
                end
            end
            S_OUT_RD: begin
                if (i_sts.out_free) begin
                    o_cmd.op = DP_OUT_RD;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and level registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_lvl   <= '0;
        end else begin
            r_state <= n_state;
            r_lvl   <= n_lvl;
        end
    end

endmodule

// ===== rtl/lcal_dpath.sv =====
// Datapath of the lowest common ancestor block: ancestor table, depth store,
// node registers, lift distance and the result register. Depends on lcal_pkg.
module lcal_dpath import lcal_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    input  logic [NODE_W-1:0] i_node_a,
    input  logic [NODE_W-1:0] i_node_b,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output logic [NODE_W-1:0] o_ancestor,
    output t_sts              o_sts
);

    localparam logic [DEPTH_W-1:0] DEPTH_MAX = {DEPTH_W{1'b1}};

    // Ancestor table: level in the upper address bits, node in the lower.
    logic [NODE_W-1:0]  anc_mem [ANC_DEPTH];
    logic [DEPTH_W-1:0] dep_mem [NODE_CAPACITY];

    logic [NODE_W-1:0]      r_a, r_b;
    logic                   r_side;
    logic [LIFT_LEVELS-1:0] r_diff;
    logic [NODE_W-1:0]      r_rd_a, r_rd_b;
    logic [DEPTH_W-1:0]     r_dep_a, r_dep_b;
    logic                   r_out_valid;
    logic [NODE_W-1:0]      r_ancestor;

    logic               anc_rd_a_en, anc_rd_b_en, anc_wr_en;
    logic [ANC_AW-1:0]  anc_rd_a_addr, anc_rd_b_addr, anc_wr_addr;
    logic [NODE_W-1:0]  anc_wr_data;
    logic               dep_rd_en, dep_wr_en;
    logic [DEPTH_W-1:0] dep_wr_data;
    logic [NODE_W-1:0]  lift_node;
    logic [DEPTH_W-1:0] depth_diff;
    logic               deeper_b;

    assign lift_node  = r_side ? r_b : r_a;
    assign deeper_b   = (r_dep_b > r_dep_a);
    assign depth_diff = deeper_b ? (r_dep_b - r_dep_a) : (r_dep_a - r_dep_b);

    // Memory port control per operation.
    always_comb begin
        anc_rd_a_en   = 1'b0;
        anc_rd_b_en   = 1'b0;
        anc_wr_en     = 1'b0;
        anc_rd_a_addr = {i_cmd.lvl, r_a};
        anc_rd_b_addr = {i_cmd.lvl, r_b};
        anc_wr_addr   = {i_cmd.lvl, r_a};
        anc_wr_data   = r_rd_a;
        dep_rd_en     = 1'b0;
        dep_wr_en     = 1'b0;
        dep_wr_data   = '0;
        unique case (i_cmd.op)
            DP_LD_BASE: begin
                // Level zero holds the parent itself.
                dep_rd_en   = 1'b1;
                anc_wr_en   = 1'b1;
                anc_wr_addr = {LVL_W'(0), r_a};
                anc_wr_data = r_b;
            end
            DP_DEP_WR: begin
                // The root sits at depth zero; others saturate at the top.
                dep_wr_en = 1'b1;
                if (r_a == r_b) begin
                    dep_wr_data = '0;
                end else if (r_dep_b == DEPTH_MAX) begin
                    dep_wr_data = DEPTH_MAX;
                end else begin
                    dep_wr_data = r_dep_b + DEPTH_W'(1);
                end
            end
            DP_DEP_RD: begin
                dep_rd_en = 1'b1;
            end
            DP_LD_RD: begin
                anc_rd_a_en   = 1'b1;
                anc_rd_a_addr = {i_cmd.lvl, r_b};
            end
            DP_LD_WR: begin
                anc_wr_en = 1'b1;
            end
            DP_LIFT_RD: begin
                anc_rd_a_en   = 1'b1;
                anc_rd_a_addr = {i_cmd.lvl, lift_node};
            end
            DP_DESC_RD: begin
                anc_rd_a_en = 1'b1;
                anc_rd_b_en = 1'b1;
            end
            DP_FIN_RD: begin
                anc_rd_a_en = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // Ancestor table: one write port, two registered read ports.
    always_ff @(posedge i_clk) begin
        if (anc_wr_en) begin
            anc_mem[anc_wr_addr] <= anc_wr_data;
        end
        if (anc_rd_a_en) begin
            r_rd_a <= anc_mem[anc_rd_a_addr];
        end
        if (anc_rd_b_en) begin
            r_rd_b <= anc_mem[anc_rd_b_addr];
        end
    end

    // Depth store: written at node a, read at both nodes.
    always_ff @(posedge i_clk) begin
        if (dep_wr_en) begin
            dep_mem[r_a] <= dep_wr_data;
        end
        if (dep_rd_en) begin
            r_dep_a <= dep_mem[r_a];
            r_dep_b <= dep_mem[r_b];
        end
    end

    // Node registers and remaining lift distance.
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            DP_CAPTURE: begin
                r_a <= i_node_a;
                r_b <= i_node_b;
            end
            DP_LD_WR: begin
                r_b <= r_rd_a;
            end
            DP_SETUP: begin
                r_side <= deeper_b;
                r_diff <= LIFT_LEVELS'(depth_diff);
            end
            DP_LIFT_WR: begin
                if (r_side) begin
                    r_b <= r_rd_a;
                end else begin
                    r_a <= r_rd_a;
                end
                r_diff <= r_diff >> 1;
            end
            DP_SHIFT: begin
                r_diff <= r_diff >> 1;
            end
            DP_DESC_UPD: begin
                if (r_rd_a != r_rd_b) begin
                    r_a <= r_rd_a;
                    r_b <= r_rd_b;
                end
            end
            default: begin
            end
        endcase
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.op == DP_OUT_A || i_cmd.op == DP_OUT_RD) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == DP_OUT_A) begin
            r_ancestor <= r_a;
        end else if (i_cmd.op == DP_OUT_RD) begin
            r_ancestor <= r_rd_a;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_ancestor      = r_ancestor;
    assign o_sts.eq        = (r_a == r_b);
    assign o_sts.diff_zero = (r_diff == '0);
    assign o_sts.diff_lsb  = r_diff[0];
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

endmodule

// ===== rtl/lowest_common_ancestor_lifting.sv =====
// Top level of the lowest common ancestor block: controller plus datapath.
// Depends on lcal_pkg, lcal_ctrl, lcal_dpath and the assertion macro header.
//
// Keeps a rooted tree of up to 16384 nodes as a 14-level binary lifting table
// and a depth store. A load request (func 0) adds node_a under parent node_b,
// the root being loaded with itself as parent; it gives no result. Each level
// above level zero is filled by reading the level below it through the
// registered table read port before writing. A query request (func 1) gives
// one ancestor result: it reads both depths, sets up the lift distance and
// the deeper side, then lifts the deeper node by walking the difference bits
// from the bottom, taking one table step per set bit, until none are left.
// When the nodes then already meet, that node is the result; otherwise it
// descends the table from the top level, reading both table entries and then
// comparing them at each level, and reads the final parent as the result.
// The controller then returns to idle, where the next request is taken.
// A finished result waits in an output register while the next request is
// accepted; a query that finds the register still full waits until it drains.
// Table and depth entries hold no value until loaded; there is no clearing
// pass after reset.
`include "lowest_common_ancestor_lifting_macros.svh"

module lowest_common_ancestor_lifting import lcal_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_func,
    input  logic [NODE_W-1:0] i_node_a,
    input  logic [NODE_W-1:0] i_node_b,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [NODE_W-1:0] o_ancestor
);

    t_cmd cmd;
    t_sts sts;
    logic req_take;
    logic load_take;
    logic dp_work;
    logic out_load;

    // Sequencer.
    lcal_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_func     (i_func),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Storage and arithmetic.
    lcal_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_node_a    (i_node_a),
        .i_node_b    (i_node_b),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_ancestor  (o_ancestor),
        .o_sts       (sts)
    );

    // Conditions watched by the checks below.
    assign req_take  = i_in_valid && o_in_ready;
    assign load_take = req_take && (i_func == FUNC_LOAD);
    assign dp_work   = (cmd.op != DP_NONE) && (cmd.op != DP_CAPTURE);
    assign out_load  = (cmd.op == DP_OUT_A) || (cmd.op == DP_OUT_RD);

    // A load request never produces a result.
    `LCAL_ASSERT_NEXT(a_load_no_result, load_take, !$rose(o_out_valid), "load produced a result")

    // Work on a request only happens while input is held off.
    `LCAL_ASSERT_NOW(a_busy_not_ready, dp_work, !o_in_ready, "input ready while busy")

    // The result register is loaded only when it is free.
    `LCAL_ASSERT_NOW(a_out_free, out_load, sts.out_free, "result overwritten before it was taken")

    // An accepted request always leaves the idle state.
    `LCAL_ASSERT_NEXT(a_accept_busy, req_take, !o_in_ready, "accepted request did not start")

endmodule
